>>> src/bfps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfps_pkg
// Types and constants shared by the blob frame parser and steering unit.
// ----------------------------------------------------------------------------
package bfps_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 10;
  localparam int CNT_W               = 4;
  localparam int MIN_FRAME_BYTES     = 5;
  localparam int QUEUE_DEPTH         = 2;

  localparam logic [7:0] HDR_FIRST  = 8'h2C;
  localparam logic [7:0] HDR_SECOND = 8'h12;
  localparam logic [7:0] END_MARK   = 8'h5B;

  localparam logic [7:0]         CENTER_OFFSET_RST = 8'd40;
  localparam logic [15:0]        STEER_GAIN_RST    = 16'd2185;
  localparam logic signed [23:0] BASE_SPEED_RST    = -24'sd65536;

  typedef enum logic [1:0] {
    CFG_CENTER_OFFSET = 2'd0,
    CFG_STEER_GAIN    = 2'd1,
    CFG_BASE_SPEED    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic        [7:0]  center_offset;
    logic        [15:0] steer_gain_q16;
    logic signed [23:0] base_speed_q16;
  } cfg_t;

  typedef struct packed {
    logic signed [7:0] blob_x;
    logic signed [7:0] blob_y;
    logic signed [7:0] blob_w;
    logic signed [7:0] blob_h;
    logic              ended_by_marker;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

>>> src/bfps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfps_front
// Byte parser: hunts the two header bytes, collects the frame and hands the
// four blob bytes of each complete frame on as one entry.
// ----------------------------------------------------------------------------
module bfps_front #(
  parameter int MAX_FRAME_BYTES = bfps_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       rx_byte,
  output logic             emit,
  output bfps_pkg::frame_t frame
);

  typedef enum logic [3:0] {
    HUNT_FIRST  = 4'b0001,
    HUNT_SECOND = 4'b0010,
    COLLECT     = 4'b0100,
    SWALLOW     = 4'b1000
  } phase_t;

  phase_t                        phase, phase_next;
  logic [bfps_pkg::CNT_W-1:0]    count, count_next;
  logic [3:0][7:0]               history;
  logic                          push;
  logic                          marker;
  logic                          at_limit;
  logic                          too_short;
  logic [bfps_pkg::CNT_W:0]      count_inc;

  assign marker    = (rx_byte == bfps_pkg::END_MARK);
  assign count_inc = {1'b0, count} + (bfps_pkg::CNT_W+1)'(1);
  assign at_limit  = count_inc >= (bfps_pkg::CNT_W+1)'(MAX_FRAME_BYTES);
  assign too_short = count_inc < (bfps_pkg::CNT_W+1)'(bfps_pkg::MIN_FRAME_BYTES);

  always_comb begin
    phase_next = phase;
    count_next = count;
    push       = 1'b0;
    emit       = 1'b0;
    if (accept) begin
      unique case (phase)
        HUNT_FIRST: begin
          if (rx_byte == bfps_pkg::HDR_FIRST) begin
            push       = 1'b1;
            phase_next = HUNT_SECOND;
          end else begin
            count_next = '0;
          end
        end
        HUNT_SECOND: begin
          if (rx_byte == bfps_pkg::HDR_SECOND) begin
            push       = 1'b1;
            phase_next = COLLECT;
          end else begin
            phase_next = HUNT_FIRST;
            count_next = '0;
          end
        end
        COLLECT: begin
          if (!(marker || at_limit)) begin
            push = 1'b1;
          end else if (too_short) begin
            // drop a frame with fewer than four bytes before its end
            phase_next = HUNT_FIRST;
            count_next = '0;
          end else begin
            emit       = 1'b1;
            push       = 1'b1;
            phase_next = SWALLOW;
          end
        end
        SWALLOW: begin
          phase_next = HUNT_FIRST;
          count_next = '0;
        end
        default: begin
          phase_next = HUNT_FIRST;
          count_next = '0;
        end
      endcase
      if (push) begin
        count_next = count_inc[bfps_pkg::CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= HUNT_FIRST;
      count <= '0;
    end else begin
      phase <= phase_next;
      count <= count_next;
    end
  end

  // history needs no clear: four pushes always precede any emitted frame
  always_ff @(posedge clk) begin
    if (push) begin
      history <= {rx_byte, history[3:1]};
    end
  end

  assign frame.blob_x          = history[0];
  assign frame.blob_y          = history[1];
  assign frame.blob_w          = history[2];
  assign frame.blob_h          = history[3];
  assign frame.ended_by_marker = marker;

endmodule

>>> src/bfps_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfps_queue
// Short queue of parsed frames between the parser and the steering math.
// ----------------------------------------------------------------------------
module bfps_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  bfps_pkg::frame_t      push_data,
  input  logic                  pop,
  output bfps_pkg::frame_t      pop_data,
  output bfps_pkg::queue_stat_t stat
);

  localparam int PTR_W  = (bfps_pkg::QUEUE_DEPTH > 1) ? $clog2(bfps_pkg::QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(bfps_pkg::QUEUE_DEPTH + 1);

  bfps_pkg::frame_t   entries [bfps_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [FILL_W-1:0]  fill;
  logic               do_push, do_pop;

  assign stat.full  = (fill == FILL_W'(bfps_pkg::QUEUE_DEPTH));
  assign stat.empty = (fill == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(bfps_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(bfps_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + FILL_W'(1);
        2'b01:   fill <= fill - FILL_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

>>> src/bfps_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfps_back
// Steering math: centred sum and gain multiply in one stage, wheel speeds
// into the output register in the next.
// ----------------------------------------------------------------------------
module bfps_back (
  input  logic                     clk,
  input  logic                     rst,
  input  bfps_pkg::cfg_t           cfg,
  input  bfps_pkg::queue_stat_t    q_stat,
  input  bfps_pkg::frame_t         q_data,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [7:0]        blob_x,
  output logic signed [7:0]        blob_y,
  output logic signed [7:0]        blob_w,
  output logic signed [7:0]        blob_h,
  output logic signed [8:0]        steer_sum,
  output logic signed [24:0]       turn_q16,
  output logic signed [25:0]       left_speed_q16,
  output logic signed [25:0]       right_speed_q16,
  output logic                     ended_by_marker
);

  logic                    a_valid, a_ready;
  bfps_pkg::frame_t        a_frame;
  logic signed [8:0]       a_sum;
  logic signed [24:0]      a_turn;

  logic signed [7:0]       cx, cy;
  logic signed [8:0]       sum;
  logic signed [25:0]      product;
  logic signed [25:0]      base_ext, turn_ext;

  assign a_ready = !out_valid || out_ready;
  assign q_pop   = !q_stat.empty && (!a_valid || a_ready);

  // centre x and fold y, both with 8-bit wrap
  assign cx      = q_data.blob_x - $signed(cfg.center_offset);
  assign cy      = (q_data.blob_w != '0) ? -q_data.blob_y : q_data.blob_y;
  assign sum     = 9'(cx) + 9'(cy);
  assign product = 26'(sum) * 26'($signed({1'b0, cfg.steer_gain_q16}));

  assign base_ext = 26'(cfg.base_speed_q16);
  assign turn_ext = 26'(a_turn);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        a_valid <= 1'b1;
      end else if (a_ready) begin
        a_valid <= 1'b0;
      end
      if (a_valid && a_ready) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_frame <= q_data;
      a_sum   <= sum;
      a_turn  <= product[24:0];
    end
    if (a_valid && a_ready) begin
      blob_x          <= a_frame.blob_x;
      blob_y          <= a_frame.blob_y;
      blob_w          <= a_frame.blob_w;
      blob_h          <= a_frame.blob_h;
      ended_by_marker <= a_frame.ended_by_marker;
      steer_sum       <= a_sum;
      turn_q16        <= a_turn;
      left_speed_q16  <= base_ext + turn_ext;
      right_speed_q16 <= base_ext - turn_ext;
    end
  end

endmodule

>>> src/blob_frame_parser_steering_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blob_frame_parser_steering_unit
// Parses header-framed blob records from a byte stream and derives a
// steering term and two wheel speeds for each complete frame.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_ready   rx_byte
//  out      source     out_valid / out_ready blob_x..h, steer_sum, turn_q16,
//                                            left/right_speed_q16,
//                                            ended_by_marker
//  cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
//  One byte is taken every cycle while in_ready is high; the parser decides
//  each byte in the cycle it arrives. A frame's result passes the queue
//  write on its last byte's edge, then the multiply stage and output register.
//  A two-entry queue absorbs output stalls; in_ready drops only when full.
//  Reset is synchronous and leaves the parser hunting for the first header.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module blob_frame_parser_steering_unit #(
  parameter int MAX_FRAME_BYTES = bfps_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [7:0]  blob_x,
  output logic signed [7:0]  blob_y,
  output logic signed [7:0]  blob_w,
  output logic signed [7:0]  blob_h,
  output logic signed [8:0]  steer_sum,
  output logic signed [24:0] turn_q16,
  output logic signed [25:0] left_speed_q16,
  output logic signed [25:0] right_speed_q16,
  output logic               ended_by_marker,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  bfps_pkg::cfg_t        cfg;
  bfps_pkg::queue_stat_t q_stat;
  bfps_pkg::frame_t      front_frame, q_data;
  logic                  front_emit;
  logic                  q_pop;
  logic                  in_accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_stat.full;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_offset  <= bfps_pkg::CENTER_OFFSET_RST;
      cfg.steer_gain_q16 <= bfps_pkg::STEER_GAIN_RST;
      cfg.base_speed_q16 <= bfps_pkg::BASE_SPEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bfps_pkg::CFG_CENTER_OFFSET) begin
        cfg.center_offset <= cfg_data[7:0];
      end
      if (cfg_index == bfps_pkg::CFG_STEER_GAIN) begin
        cfg.steer_gain_q16 <= cfg_data[15:0];
      end
      if (cfg_index == bfps_pkg::CFG_BASE_SPEED) begin
        cfg.base_speed_q16 <= cfg_data;
      end
    end
  end

  bfps_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (in_accept),
    .rx_byte (rx_byte),
    .emit    (front_emit),
    .frame   (front_frame)
  );

  bfps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_emit),
    .push_data (front_frame),
    .pop       (q_pop),
    .pop_data  (q_data),
    .stat      (q_stat)
  );

  bfps_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_stat          (q_stat),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .blob_x          (blob_x),
    .blob_y          (blob_y),
    .blob_w          (blob_w),
    .blob_h          (blob_h),
    .steer_sum       (steer_sum),
    .turn_q16        (turn_q16),
    .left_speed_q16  (left_speed_q16),
    .right_speed_q16 (right_speed_q16),
    .ended_by_marker (ended_by_marker)
  );

  logic signed [26:0] speed_sum, speed_diff, base_twice, turn_twice;

  assign speed_sum  = 27'(left_speed_q16) + 27'(right_speed_q16);
  assign speed_diff = 27'(left_speed_q16) - 27'(right_speed_q16);
  assign base_twice = {27'(cfg.base_speed_q16)} <<< 1;
  assign turn_twice = {27'(turn_q16)} <<< 1;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    front_emit |-> !q_stat.full)
    else $error("frame emitted into a full queue");

  a_speed_mean: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (speed_sum == base_twice))
    else $error("wheel speeds do not center on base speed");

  a_speed_split: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (speed_diff == turn_twice))
    else $error("wheel speed difference does not match turn term");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives camera bytes into the blob frame parser and steering unit through
// its valid/ready channels and scores every frame result in order against a
// cycle-free model of the parser, the centering, the gain multiply and the
// wheel speed sums. A short directed byte table comes first, followed by
// several register settings, each with a mix of random frames, short
// frames, swallowed bytes and line noise.
// ----------------------------------------------------------------------------
module testbench;

  localparam int ITEMS_PER_PHASE  = 105;
  localparam int N_PHASES         = 5;
  localparam int DIR_ROWS         = 25;
  localparam int ROW_ZERO_BLOB    = 10;
  localparam int ROW_EXTREME_BLOB = 23;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT      = 5000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int RUN_LIMIT_NS     = 4_000_000;

  typedef enum logic [1:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    COLLECT,
    SWALLOW
  } parse_phase_t;

  typedef struct packed {
    logic signed [7:0]  x;
    logic signed [7:0]  y;
    logic signed [7:0]  w;
    logic signed [7:0]  h;
    logic signed [8:0]  sum;
    logic signed [24:0] turn;
    logic signed [25:0] left;
    logic signed [25:0] right;
    logic               marker;
  } steer_res_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         rx_byte;
  logic               out_valid;
  logic               out_ready;
  logic signed [7:0]  blob_x;
  logic signed [7:0]  blob_y;
  logic signed [7:0]  blob_w;
  logic signed [7:0]  blob_h;
  logic signed [8:0]  steer_sum;
  logic signed [24:0] turn_q16;
  logic signed [25:0] left_speed_q16;
  logic signed [25:0] right_speed_q16;
  logic               ended_by_marker;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [23:0]        cfg_data;

  // register copies and parser state of the model
  logic [7:0]         shadow_offset;
  logic [15:0]        shadow_gain;
  logic signed [23:0] shadow_base;
  parse_phase_t       prs_phase;
  logic [3:0]         prs_count;
  logic [7:0]         prs_hist [4];

  steer_res_t pending_frames [$];
  int         err_count;
  bit         calm_idle;
  bit         pressure_go;

  logic [7:0] dir_bytes [DIR_ROWS] = '{
    8'h55,
    bfps_pkg::HDR_FIRST, bfps_pkg::HDR_SECOND, bfps_pkg::END_MARK,
    bfps_pkg::HDR_FIRST, bfps_pkg::HDR_SECOND, 8'h28, 8'h00, 8'h00, 8'h00,
    bfps_pkg::END_MARK,
    bfps_pkg::HDR_FIRST,
    bfps_pkg::HDR_FIRST, bfps_pkg::HDR_FIRST,
    bfps_pkg::HDR_FIRST, bfps_pkg::HDR_SECOND, 8'h00, 8'h00, 8'h00, 8'h7F,
    8'h80, 8'h01, 8'h80,
    bfps_pkg::END_MARK,
    8'hFF
  };

  steer_res_t zero_blob = '{8'sd40, 8'sd0, 8'sd0, 8'sd0, 9'sd0, 25'sd0,
                            -26'sd65536, -26'sd65536, 1'b1};
  steer_res_t extreme_blob = '{8'sd127, -8'sd128, 8'sd1, -8'sd128, -9'sd41,
                               -25'sd89585, -26'sd155121, 26'sd24049, 1'b1};

  blob_frame_parser_steering_unit u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .blob_x          (blob_x),
    .blob_y          (blob_y),
    .blob_w          (blob_w),
    .blob_h          (blob_h),
    .steer_sum       (steer_sum),
    .turn_q16        (turn_q16),
    .left_speed_q16  (left_speed_q16),
    .right_speed_q16 (right_speed_q16),
    .ended_by_marker (ended_by_marker),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  function automatic void log_fail(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic void clear_parser();
    prs_phase = HUNT_FIRST;
    prs_count = '0;
    for (int k = 0; k < 4; k++) prs_hist[k] = '0;
  endfunction

  function automatic void push_hist(input logic [7:0] b);
    prs_hist[0] = prs_hist[1];
    prs_hist[1] = prs_hist[2];
    prs_hist[2] = prs_hist[3];
    prs_hist[3] = b;
    prs_count   = prs_count + 4'd1;
  endfunction

  // Advance the parser by one byte; return 1 when the byte completes a frame.
  function automatic bit parse_rx_byte(input logic [7:0] b, output steer_res_t r);
    logic signed [7:0] cx;
    logic signed [7:0] cy;
    bit                at_mark;
    int                next_cnt;
    r        = '0;
    next_cnt = int'(prs_count) + 1;
    at_mark  = (b == bfps_pkg::END_MARK);
    if (prs_phase == HUNT_FIRST && b == bfps_pkg::HDR_FIRST) begin
      prs_phase = HUNT_SECOND;
      push_hist(b);
      return 0;
    end
    if (prs_phase == HUNT_SECOND && b == bfps_pkg::HDR_SECOND) begin
      prs_phase = COLLECT;
      push_hist(b);
      return 0;
    end
    // swallow phase and any stray byte drop back to hunting
    if (prs_phase != COLLECT) begin
      clear_parser();
      return 0;
    end
    if (!at_mark && next_cnt < bfps_pkg::MAX_FRAME_BYTES_DEF) begin
      push_hist(b);
      return 0;
    end
    // too few bytes ahead of the terminator to hold x, y, w, h
    if (next_cnt < bfps_pkg::MIN_FRAME_BYTES) begin
      clear_parser();
      return 0;
    end
    r.x      = prs_hist[0];
    r.y      = prs_hist[1];
    r.w      = prs_hist[2];
    r.h      = prs_hist[3];
    r.marker = at_mark;
    push_hist(b);
    prs_phase = SWALLOW;
    cx      = r.x - shadow_offset;
    cy      = (r.w != 0) ? -r.y : r.y;
    r.sum   = 9'(cx) + 9'(cy);
    r.turn  = 25'(r.sum) * 25'($signed({1'b0, shadow_gain}));
    r.left  = 26'(shadow_base) + 26'(r.turn);
    r.right = 26'(shadow_base) - 26'(r.turn);
    return 1;
  endfunction

  // Call at a falling edge; returns at a falling edge after the item and its gap.
  task automatic send_byte(input logic [7:0] b, input bit typed,
                           input steer_res_t typed_res);
    steer_res_t r;
    int         gap;
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    if (parse_rx_byte(b, r)) pending_frames.push_back(typed ? typed_res : r);
    @(negedge clk);
    gap = calm_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(input bfps_pkg::cfg_idx_t idx, input logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bfps_pkg::CFG_CENTER_OFFSET: shadow_offset = data[7:0];
      bfps_pkg::CFG_STEER_GAIN:    shadow_gain   = data[15:0];
      default:                     shadow_base   = data;
    endcase
    @(negedge clk);
  endtask

  task automatic drain_frames();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (pending_frames.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

  // receiver: random back-pressure, plus one long hold while frames pile up
  initial begin
    int  gap;
    bit  held_long;
    out_ready = 1'b0;
    held_long = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_go && !held_long) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        held_long = 1'b1;
      end else begin
        gap = calm_idle ? 0 : pick_gap();
        if (gap == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  end

  initial begin
    steer_res_t seen;
    steer_res_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        seen = '{blob_x, blob_y, blob_w, blob_h, steer_sum, turn_q16,
                 left_speed_q16, right_speed_q16, ended_by_marker};
        if (pending_frames.size() == 0) begin
          log_fail($sformatf("unexpected frame result at %0t", $realtime));
        end else begin
          want = pending_frames.pop_front();
          if (seen.x !== want.x || seen.y !== want.y || seen.w !== want.w ||
              seen.h !== want.h || seen.sum !== want.sum ||
              seen.turn !== want.turn || seen.left !== want.left ||
              seen.right !== want.right || seen.marker !== want.marker)
            log_fail($sformatf({"frame mismatch at %0t\n",
              "  exp x=%0d y=%0d w=%0d h=%0d sum=%0d turn=%0d l=%0d r=%0d m=%0b\n",
              "  got x=%0d y=%0d w=%0d h=%0d sum=%0d turn=%0d l=%0d r=%0d m=%0b"},
              $realtime,
              want.x, want.y, want.w, want.h, want.sum, want.turn, want.left,
              want.right, want.marker,
              seen.x, seen.y, seen.w, seen.h, seen.sum, seen.turn, seen.left,
              seen.right, seen.marker));
        end
      end
    end
  end

  initial begin
    int          fb;
    int          kind;
    int          plen;
    int          nlen;
    logic [7:0]  off;
    logic [15:0] gain;
    logic [23:0] base;
    rst           = 1'b1;
    in_valid      = 1'b0;
    rx_byte       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = bfps_pkg::CFG_CENTER_OFFSET;
    cfg_data      = '0;
    err_count     = 0;
    calm_idle     = 1'b0;
    pressure_go   = 1'b0;
    shadow_offset = bfps_pkg::CENTER_OFFSET_RST;
    shadow_gain   = bfps_pkg::STEER_GAIN_RST;
    shadow_base   = bfps_pkg::BASE_SPEED_RST;
    clear_parser();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table under reset register values
    for (int i = 0; i < DIR_ROWS; i++)
      send_byte(dir_bytes[i], i == ROW_ZERO_BLOB || i == ROW_EXTREME_BLOB,
                (i == ROW_ZERO_BLOB) ? zero_blob : extreme_blob);
    drain_frames();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin off = 8'd0;   gain = 16'hFFFF; base = 24'h800000; end
        1: begin off = 8'd255; gain = 16'd0;    base = 24'h7FFFFF; end
        2: begin
          off  = bfps_pkg::CENTER_OFFSET_RST;
          gain = bfps_pkg::STEER_GAIN_RST;
          base = bfps_pkg::BASE_SPEED_RST;
        end
        default: begin
          off  = 8'($urandom_range(0, 255));
          gain = 16'($urandom_range(0, 65535));
          base = 24'($urandom);
        end
      endcase
      write_reg(bfps_pkg::CFG_CENTER_OFFSET, {16'd0, off});
      write_reg(bfps_pkg::CFG_STEER_GAIN, {8'd0, gain});
      write_reg(bfps_pkg::CFG_BASE_SPEED, base);
      cfg_valid <= 1'b0;
      calm_idle   = (ph == 3);
      pressure_go = (ph >= 1);

      fb = 0;
      while (fb < ITEMS_PER_PHASE) begin
        kind = $urandom_range(0, 99);
        if (kind < 85) begin
          // mostly well-formed frames with random content
          if (kind < 55)      plen = $urandom_range(2, 7);
          else if (kind < 75) plen = 8;
          else                plen = $urandom_range(0, 1);
          send_byte(bfps_pkg::HDR_FIRST, 1'b0, '0);
          send_byte(bfps_pkg::HDR_SECOND, 1'b0, '0);
          for (int j = 0; j < plen; j++)
            send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
          if (plen < 8) send_byte(bfps_pkg::END_MARK, 1'b0, '0);
          // byte after a completed frame is dropped by the parser
          if (plen >= 2) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
          fb += plen + 2 + ((plen < 8) ? 1 : 0) + ((plen >= 2) ? 1 : 0);
        end else begin
          nlen = $urandom_range(1, 4);
          for (int j = 0; j < nlen; j++)
            send_byte((j == 0 && $urandom_range(0, 1) == 1) ? bfps_pkg::HDR_FIRST
                      : 8'($urandom_range(0, 255)), 1'b0, '0);
          fb += nlen;
        end
      end
      drain_frames();
    end

    if (pending_frames.size() != 0)
      log_fail($sformatf("%0d frame results never arrived", pending_frames.size()));
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
